// ===== src/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg
// shared types, constants and character helpers of the column consensus block
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned MID_DEPTH_LOG2  = 2;
  localparam int unsigned OUT_DEPTH_LOG2  = 1;

  // register indexes (word address)
  localparam logic REG_AMBIGUITY_MODE = 1'b0;

  localparam logic [7:0] CHAR_GAP   = 8'h2d;  // '-'
  localparam logic [7:0] CHAR_MASK  = 8'h4e;  // 'N'
  localparam logic [7:0] CHAR_U     = 8'h55;  // 'U'
  localparam logic [7:0] CHAR_T     = 8'h54;  // 'T'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LC_Z  = 8'h7a;  // 'z'
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [3:0] SET_NONE = 4'b0000;
  localparam logic [3:0] SET_A    = 4'b0001;
  localparam logic [3:0] SET_T    = 4'b0010;
  localparam logic [3:0] SET_C    = 4'b0100;
  localparam logic [3:0] SET_G    = 4'b1000;

  // one classified character travelling from front to back
  typedef struct packed {
    logic [7:0] sym;
    logic       gap;
    logic [3:0] bset;
    logic       last;
  } acc_item_t;

  // one finished column
  typedef struct packed {
    logic [7:0] sym;
    logic       bad;
  } acc_result_t;

  function automatic logic [7:0] clean_symbol(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      u = c - CASE_DELTA;
    end
    if (u == CHAR_U) begin
      u = CHAR_T;
    end
    return u;
  endfunction

  function automatic logic [3:0] code_set(input logic [7:0] c);
    logic [3:0] s;
    unique case (c)
      8'h41:   s = SET_A;                         // A
      8'h54:   s = SET_T;                         // T
      8'h43:   s = SET_C;                         // C
      8'h47:   s = SET_G;                         // G
      8'h52:   s = SET_A | SET_G;                 // R
      8'h59:   s = SET_C | SET_T;                 // Y
      8'h4b:   s = SET_G | SET_T;                 // K
      8'h4d:   s = SET_A | SET_C;                 // M
      8'h53:   s = SET_C | SET_G;                 // S
      8'h57:   s = SET_A | SET_T;                 // W
      8'h42:   s = SET_C | SET_G | SET_T;         // B
      8'h44:   s = SET_A | SET_G | SET_T;         // D
      8'h48:   s = SET_A | SET_C | SET_T;         // H
      8'h56:   s = SET_A | SET_C | SET_G;         // V
      8'h4e:   s = SET_A | SET_C | SET_G | SET_T; // N
      default: s = SET_NONE;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] set_letter(input logic [3:0] s);
    logic [7:0] c;
    unique case (s)
      4'd1:    c = 8'h41; // A
      4'd2:    c = 8'h54; // T
      4'd3:    c = 8'h57; // W
      4'd4:    c = 8'h43; // C
      4'd5:    c = 8'h4d; // M
      4'd6:    c = 8'h59; // Y
      4'd7:    c = 8'h48; // H
      4'd8:    c = 8'h47; // G
      4'd9:    c = 8'h52; // R
      4'd10:   c = 8'h4b; // K
      4'd11:   c = 8'h44; // D
      4'd12:   c = 8'h53; // S
      4'd13:   c = 8'h56; // V
      4'd14:   c = 8'h42; // B
      default: c = CHAR_MASK;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/alignment_column_consensus.sv =====
// ----------------------------------------------------------------------------
// alignment_column_consensus
// per-column consensus of an alignment, strict or IUPAC ambiguity union
// ----------------------------------------------------------------------------
// result path: the last word of a column goes through the middle queue, its
//   result into the output queue, shown (empty low) when none waits ahead
// throughput: one word per cycle while the output queue has room, set by the
//   column fold in the back end; the two queues let either side stall on its own
// reset (rst_n low, synchronous): queues empty, column state cleared,
//   ambiguity_mode back to strict
`default_nettype none

module alignment_column_consensus #(
  parameter int unsigned MID_DEPTH_LOG2 = acc_pkg::MID_DEPTH_LOG2,
  parameter int unsigned OUT_DEPTH_LOG2 = acc_pkg::OUT_DEPTH_LOG2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // character words
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [7:0]                     in_symbol,
  input  wire logic                           in_column_end,
  // consensus words
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          out_consensus_symbol,
  output logic                                out_bad_symbol,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [acc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [acc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [acc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);

  import acc_pkg::*;

  logic      mode_r;
  logic      reg_sel;
  logic      cfg_wr;
  acc_item_t item;
  logic      item_empty;
  logic      item_pop;

  // ---------------------------------------------------------------------------
  // register port: one register at byte 0, the word index is paddr[2]
  // low address bits are byte lanes and are ignored
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_AMBIGUITY_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && reg_sel) begin
      mode_r <= pwdata[0];
    end
  end

  // reads of an address beyond the register return zero
  assign prdata = reg_sel ? {{(CFG_DATA_W - 1){1'b0}}, mode_r} : '0;

  // ---------------------------------------------------------------------------
  // front end: upper-case, U to T, gap detect and base-set lookup, then queue
  // ---------------------------------------------------------------------------
  acc_front #(
    .DEPTH_LOG2 (MID_DEPTH_LOG2)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_symbol     (in_symbol),
    .in_column_end (in_column_end),
    .item_pop      (item_pop),
    .item          (item),
    .item_empty    (item_empty)
  );

  // ---------------------------------------------------------------------------
  // back end: column fold and consensus decode; the mode is sampled when a
  // column closes; the user must change the register only while idle, which
  // the block itself does not enforce
  acc_back #(
    .DEPTH_LOG2 (OUT_DEPTH_LOG2)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ambiguity_mode       (mode_r),
    .item                 (item),
    .item_empty           (item_empty),
    .item_pop             (item_pop),
    .pop                  (pop),
    .empty                (empty),
    .out_consensus_symbol (out_consensus_symbol),
    .out_bad_symbol       (out_bad_symbol)
  );

endmodule

`default_nettype wire

// ===== src/acc_fifo.sv =====
// ----------------------------------------------------------------------------
// acc_fifo
// small register queue with full/empty flags
// ----------------------------------------------------------------------------
`default_nettype none

module acc_fifo #(
  parameter int unsigned WIDTH      = 8,
  parameter int unsigned DEPTH_LOG2 = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;
  localparam logic [DEPTH_LOG2:0] FULL_CNT = (DEPTH_LOG2 + 1)'(DEPTH);

  logic [WIDTH-1:0]      entry_r [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [DEPTH_LOG2-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [DEPTH_LOG2:0]   count_r, count_nxt;
  logic                  do_wr, do_rd;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/acc_front.sv =====
// ----------------------------------------------------------------------------
// acc_front
// accepts characters, cleans and classifies them into the middle queue
// ----------------------------------------------------------------------------
`default_nettype none

module acc_front #(
  parameter int unsigned DEPTH_LOG2 = acc_pkg::MID_DEPTH_LOG2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        in_symbol,
  input  wire logic              in_column_end,
  input  wire logic              item_pop,
  output acc_pkg::acc_item_t     item,
  output logic                   item_empty
);

  import acc_pkg::*;

  acc_item_t  in_item;
  logic [7:0] clean;

  always_comb begin
    clean        = clean_symbol(in_symbol);
    in_item.sym  = clean;
    in_item.gap  = (clean == CHAR_GAP);
    in_item.bset = in_item.gap ? SET_NONE : code_set(clean);
    in_item.last = in_column_end;
  end

  acc_fifo #(
    .WIDTH      ($bits(acc_item_t)),
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_item),
    .full    (full),
    .rd_en   (item_pop),
    .rd_data (item),
    .empty   (item_empty)
  );

endmodule

`default_nettype wire

// ===== src/acc_back.sv =====
// ----------------------------------------------------------------------------
// acc_back
// folds classified characters into the column state and emits the consensus
// ----------------------------------------------------------------------------
`default_nettype none

module acc_back #(
  parameter int unsigned DEPTH_LOG2 = acc_pkg::OUT_DEPTH_LOG2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               ambiguity_mode,
  input  wire acc_pkg::acc_item_t item,
  input  wire logic               item_empty,
  output logic                    item_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic [7:0]              out_consensus_symbol,
  output logic                    out_bad_symbol
);

  import acc_pkg::*;

  logic        started_r, started_nxt;
  logic [7:0]  ref_r, ref_nxt;
  logic        mis_r, mis_nxt;
  logic        gap_r, gap_nxt;
  logic [3:0]  set_r, set_nxt;
  logic        inv_r, inv_nxt;
  logic        out_full;
  logic        res_push;
  acc_result_t res, res_head;

  assign item_pop = !item_empty && !out_full;
  assign res_push = item_pop && item.last;

  always_comb begin
    // column state including this word
    gap_nxt     = gap_r | item.gap;
    inv_nxt     = inv_r | (!item.gap && item.bset == SET_NONE);
    ref_nxt     = started_r ? ref_r : item.sym;
    mis_nxt     = mis_r | (started_r && item.sym != ref_r);
    set_nxt     = set_r | item.bset;
    started_nxt = 1'b1;

    res.bad = 1'b0;
    priority if (gap_nxt) begin
      res.sym = CHAR_GAP;
    end else if (!ambiguity_mode) begin
      res.sym = mis_nxt ? CHAR_MASK : ref_nxt;
    end else if (inv_nxt || set_nxt == SET_NONE) begin
      res.sym = CHAR_MASK;
      res.bad = 1'b1;
    end else begin
      res.sym = set_letter(set_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      ref_r     <= '0;
      mis_r     <= 1'b0;
      gap_r     <= 1'b0;
      set_r     <= SET_NONE;
      inv_r     <= 1'b0;
    end else if (item_pop) begin
      if (item.last) begin
        started_r <= 1'b0;
        ref_r     <= '0;
        mis_r     <= 1'b0;
        gap_r     <= 1'b0;
        set_r     <= SET_NONE;
        inv_r     <= 1'b0;
      end else begin
        started_r <= started_nxt;
        ref_r     <= ref_nxt;
        mis_r     <= mis_nxt;
        gap_r     <= gap_nxt;
        set_r     <= set_nxt;
        inv_r     <= inv_nxt;
      end
    end
  end

  acc_fifo #(
    .WIDTH      ($bits(acc_result_t)),
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_consensus_symbol = res_head.sym;
  assign out_bad_symbol       = res_head.bad;

endmodule

`default_nettype wire
